// ===== sv/cmi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_pkg: shared types and constants of the complex 2x2 matrix inverse
// Holds the transaction structs of both channels and the fixed formats.
// ----------------------------------------------------------------------------
package cmi_pkg;

   // Width of each input part, two's complement with DATA_WIDTH-1 fraction bits
   localparam int DATA_WIDTH = 16;

   // Result parts are signed Q16.16
   localparam int Q_W        = 32;
   localparam int Q_FRAC     = 16;
   localparam int DIV_STAGES = Q_W;

   localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] Q_NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] a11_re;
      logic signed [DATA_WIDTH-1:0] a11_im;
      logic signed [DATA_WIDTH-1:0] a12_re;
      logic signed [DATA_WIDTH-1:0] a12_im;
      logic signed [DATA_WIDTH-1:0] a21_re;
      logic signed [DATA_WIDTH-1:0] a21_im;
      logic signed [DATA_WIDTH-1:0] a22_re;
      logic signed [DATA_WIDTH-1:0] a22_im;
   } cmi_req_type;

   typedef struct packed {
      logic signed [Q_W-1:0] b11_re;
      logic signed [Q_W-1:0] b11_im;
      logic signed [Q_W-1:0] b12_re;
      logic signed [Q_W-1:0] b12_im;
      logic signed [Q_W-1:0] b21_re;
      logic signed [Q_W-1:0] b21_im;
      logic signed [Q_W-1:0] b22_re;
      logic signed [Q_W-1:0] b22_im;
      logic                  singular;
   } cmi_rsp_type;

endpackage
`default_nettype wire

// ===== sv/complex_matrix2x2_inverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_matrix2x2_inverse: pipelined inverse of a complex 2x2 matrix
// Exact determinant, exact complex division, Q16.16 saturated results.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one matrix per transaction (eight signed Q1.15
//   parts); the rsp channel returns its inverse as eight signed Q16.16 parts
//   plus a singular flag (zero determinant, or any part saturated). A zero
//   determinant returns all parts zero.
//   From the accepting edge to rsp_valid a matrix passes six arithmetic
//   stages (products, determinant, partial products, sums, magnitude, range
//   check), 32 restoring division stages that each settle one quotient bit of
//   all eight parts, and the output register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   the one-bit-per-stage divider sets the depth, not the rate.
//   Reset clears every stage valid bit; rsp_valid is low after reset.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   req_ready falls; nothing is lost or repeated. Empty stages are not
//   filled during a stall.
// ----------------------------------------------------------------------------
module complex_matrix2x2_inverse (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  cmi_pkg::cmi_req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output cmi_pkg::cmi_rsp_type  rsp_data
);
   import cmi_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int PW  = 2 * W;            // input product
   localparam int DW  = 2 * W + 2;        // determinant part
   localparam int H   = W + 1;            // low split of determinant part
   localparam int HW  = DW - H;           // high split
   localparam int EW  = W + 1;            // negated input part
   localparam int NW  = 3 * W + 2;        // numerator
   localparam int MW  = 4 * W + 2;        // |D|^2
   localparam int CW  = MW + Q_W;         // divider remainder
   localparam int SC  = W - 1 + Q_FRAC;   // numerator scale
   localparam int NST = 6 + DIV_STAGES + 1;

   logic en;
   logic vld_ff [0:NST-1];

   // Advance the pipeline unless a result waits at the output
   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NST-1];

   // Shift valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < NST; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // ---- stage 1: input products
   logic signed [W-1:0]  x_in [0:7];
   logic signed [W-1:0]  x_s1_ff [0:7];
   logic signed [PW-1:0] p_s1_in [0:7];
   logic signed [PW-1:0] p_s1_ff [0:7];

   always_comb begin
      x_in[0] = req_data.a11_re;
      x_in[1] = req_data.a11_im;
      x_in[2] = req_data.a12_re;
      x_in[3] = req_data.a12_im;
      x_in[4] = req_data.a21_re;
      x_in[5] = req_data.a21_im;
      x_in[6] = req_data.a22_re;
      x_in[7] = req_data.a22_im;
      p_s1_in[0] = x_in[0] * x_in[6];
      p_s1_in[1] = x_in[1] * x_in[7];
      p_s1_in[2] = x_in[2] * x_in[4];
      p_s1_in[3] = x_in[3] * x_in[5];
      p_s1_in[4] = x_in[0] * x_in[7];
      p_s1_in[5] = x_in[1] * x_in[6];
      p_s1_in[6] = x_in[2] * x_in[5];
      p_s1_in[7] = x_in[3] * x_in[4];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            x_s1_ff[i] <= x_in[i];
            p_s1_ff[i] <= p_s1_in[i];
         end
      end
   end

   // ---- stage 2: determinant and numerator parts
   logic signed [DW-1:0] d_s2_in [0:1];
   logic signed [DW-1:0] d_s2_ff [0:1];
   logic signed [EW-1:0] e_s2_in [0:7];
   logic signed [EW-1:0] e_s2_ff [0:7];

   always_comb begin
      d_s2_in[0] = DW'(p_s1_ff[0]) - DW'(p_s1_ff[1]) - DW'(p_s1_ff[2]) + DW'(p_s1_ff[3]);
      d_s2_in[1] = DW'(p_s1_ff[4]) + DW'(p_s1_ff[5]) - DW'(p_s1_ff[6]) - DW'(p_s1_ff[7]);
      e_s2_in[0] = EW'(x_s1_ff[6]);
      e_s2_in[1] = EW'(x_s1_ff[7]);
      e_s2_in[2] = -EW'(x_s1_ff[2]);
      e_s2_in[3] = -EW'(x_s1_ff[3]);
      e_s2_in[4] = -EW'(x_s1_ff[4]);
      e_s2_in[5] = -EW'(x_s1_ff[5]);
      e_s2_in[6] = EW'(x_s1_ff[0]);
      e_s2_in[7] = EW'(x_s1_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) d_s2_ff[j] <= d_s2_in[j];
         for (int i = 0; i < 8; i++) e_s2_ff[i] <= e_s2_in[i];
      end
   end

   // ---- stage 3: partial products on split determinant parts
   logic signed [HW-1:0]      dhi [0:1];
   logic signed [H:0]         dlo [0:1];
   logic signed [2*HW-1:0]    hh_s3_in [0:1];
   logic signed [HW+H:0]      hl_s3_in [0:1];
   logic signed [2*H+1:0]     ll_s3_in [0:1];
   logic signed [2*HW-1:0]    hh_s3_ff [0:1];
   logic signed [HW+H:0]      hl_s3_ff [0:1];
   logic signed [2*H+1:0]     ll_s3_ff [0:1];
   logic signed [EW+HW-1:0]   ph_s3_in [0:7][0:1];
   logic signed [EW+H:0]      pl_s3_in [0:7][0:1];
   logic signed [EW+HW-1:0]   ph_s3_ff [0:7][0:1];
   logic signed [EW+H:0]      pl_s3_ff [0:7][0:1];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         dhi[j]      = d_s2_ff[j][DW-1:H];
         dlo[j]      = $signed({1'b0, d_s2_ff[j][H-1:0]});
         hh_s3_in[j] = dhi[j] * dhi[j];
         hl_s3_in[j] = dhi[j] * dlo[j];
         ll_s3_in[j] = dlo[j] * dlo[j];
         for (int i = 0; i < 8; i++) begin
            ph_s3_in[i][j] = e_s2_ff[i] * dhi[j];
            pl_s3_in[i][j] = e_s2_ff[i] * dlo[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            hh_s3_ff[j] <= hh_s3_in[j];
            hl_s3_ff[j] <= hl_s3_in[j];
            ll_s3_ff[j] <= ll_s3_in[j];
            for (int i = 0; i < 8; i++) begin
               ph_s3_ff[i][j] <= ph_s3_in[i][j];
               pl_s3_ff[i][j] <= pl_s3_in[i][j];
            end
         end
      end
   end

   // ---- stage 4: |D|^2 and the eight numerators
   logic signed [MW:0]   sq [0:1];
   logic signed [MW:0]   m_sum;
   logic [MW-1:0]        m_s4_in;
   logic [MW-1:0]        m_s4_ff;
   logic signed [NW-1:0] n_s4_in [0:7];
   logic signed [NW-1:0] n_s4_ff [0:7];
   logic signed [NW-1:0] nhi;
   logic signed [NW-1:0] nlo;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         sq[j] = ((MW+1)'(hh_s3_ff[j]) <<< (2 * H)) + ((MW+1)'(hl_s3_ff[j]) <<< (H + 1))
               + (MW+1)'(ll_s3_ff[j]);
      end
      m_sum   = sq[0] + sq[1];
      m_s4_in = m_sum[MW-1:0];
      nhi     = '0;
      nlo     = '0;
      for (int k = 0; k < 4; k++) begin
         // real part: e0*dr + e1*di
         nhi = NW'(ph_s3_ff[2*k][0]) + NW'(ph_s3_ff[2*k+1][1]);
         nlo = NW'(pl_s3_ff[2*k][0]) + NW'(pl_s3_ff[2*k+1][1]);
         n_s4_in[2*k] = (nhi <<< H) + nlo;
         // imaginary part: e1*dr - e0*di
         nhi = NW'(ph_s3_ff[2*k+1][0]) - NW'(ph_s3_ff[2*k][1]);
         nlo = NW'(pl_s3_ff[2*k+1][0]) - NW'(pl_s3_ff[2*k][1]);
         n_s4_in[2*k+1] = (nhi <<< H) + nlo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_s4_ff <= m_s4_in;
         for (int i = 0; i < 8; i++) n_s4_ff[i] <= n_s4_in[i];
      end
   end

   // ---- stage 5: sign and magnitude, zero determinant
   logic signed [NW-1:0] nabs [0:7];
   logic [NW-2:0]        mag_s5_ff [0:7];
   logic                 neg_s5_ff [0:7];
   logic [MW-1:0]        m_s5_ff;
   logic                 zero_s5_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         nabs[i] = n_s4_ff[i][NW-1] ? -n_s4_ff[i] : n_s4_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            mag_s5_ff[i] <= nabs[i][NW-2:0];
            neg_s5_ff[i] <= n_s4_ff[i][NW-1];
         end
         m_s5_ff    <= m_s4_ff;
         zero_s5_ff <= (m_s4_ff == '0);
      end
   end

   // ---- stage 6: scale numerators, flag quotients of 2^32 or more
   logic [CW-1:0] a_s6 [0:7];
   logic [CW-1:0] r_s6_ff [0:7];
   logic          ovf_s6_ff [0:7];
   logic          neg_s6_ff [0:7];
   logic [MW-1:0] m_s6_ff;
   logic          zero_s6_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) a_s6[i] = CW'(mag_s5_ff[i]) << SC;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            r_s6_ff[i]   <= a_s6[i];
            ovf_s6_ff[i] <= a_s6[i] >= (CW'(m_s5_ff) << Q_W);
            neg_s6_ff[i] <= neg_s5_ff[i];
         end
         m_s6_ff    <= m_s5_ff;
         zero_s6_ff <= zero_s5_ff;
      end
   end

   // ---- division stages: one quotient bit per stage, MSB first
   logic [CW-1:0]  dv_r_ff   [0:DIV_STAGES-1][0:7];
   logic [Q_W-1:0] dv_q_ff   [0:DIV_STAGES-1][0:7];
   logic           dv_ovf_ff [0:DIV_STAGES-1][0:7];
   logic           dv_neg_ff [0:DIV_STAGES-1][0:7];
   logic [MW-1:0]  dv_m_ff   [0:DIV_STAGES-1];
   logic           dv_z_ff   [0:DIV_STAGES-1];
   logic [CW-1:0]  dv_r_in   [0:DIV_STAGES-1][0:7];
   logic [Q_W-1:0] dv_q_in   [0:DIV_STAGES-1][0:7];
   logic [CW-1:0]  r_prev;
   logic [Q_W-1:0] q_prev;
   logic [MW-1:0]  m_prev;
   logic [CW-1:0]  trial;

   always_comb begin
      r_prev = '0;
      q_prev = '0;
      m_prev = '0;
      trial  = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         m_prev = (k == 0) ? m_s6_ff : dv_m_ff[k-1];
         for (int i = 0; i < 8; i++) begin
            r_prev = (k == 0) ? r_s6_ff[i] : dv_r_ff[k-1][i];
            q_prev = (k == 0) ? '0 : dv_q_ff[k-1][i];
            trial  = CW'(m_prev) << (DIV_STAGES - 1 - k);
            if (r_prev >= trial) begin
               dv_r_in[k][i] = r_prev - trial;
               dv_q_in[k][i] = q_prev | (Q_W'(1) << (DIV_STAGES - 1 - k));
            end else begin
               dv_r_in[k][i] = r_prev;
               dv_q_in[k][i] = q_prev;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_m_ff[k] <= (k == 0) ? m_s6_ff : dv_m_ff[k-1];
            dv_z_ff[k] <= (k == 0) ? zero_s6_ff : dv_z_ff[k-1];
            for (int i = 0; i < 8; i++) begin
               dv_r_ff[k][i]   <= dv_r_in[k][i];
               dv_q_ff[k][i]   <= dv_q_in[k][i];
               dv_ovf_ff[k][i] <= (k == 0) ? ovf_s6_ff[i] : dv_ovf_ff[k-1][i];
               dv_neg_ff[k][i] <= (k == 0) ? neg_s6_ff[i] : dv_neg_ff[k-1][i];
            end
         end
      end
   end

   // ---- output stage: apply sign, saturate, drop results of a zero determinant
   localparam int LD = DIV_STAGES - 1;
   logic [Q_W-1:0] res   [0:7];
   logic           sat   [0:7];
   logic           any_sat;
   logic [Q_W-1:0] qv;
   cmi_rsp_type    rsp_in;
   cmi_rsp_type    rsp_data_ff;

   always_comb begin
      any_sat = 1'b0;
      qv      = '0;
      for (int i = 0; i < 8; i++) begin
         qv = dv_q_ff[LD][i];
         if (!dv_neg_ff[LD][i]) begin
            sat[i] = dv_ovf_ff[LD][i] || (qv > Q_POS_MAX);
            res[i] = sat[i] ? Q_POS_MAX : qv;
         end else begin
            sat[i] = dv_ovf_ff[LD][i] || (qv > Q_NEG_MAX);
            res[i] = sat[i] ? Q_NEG_MAX : (~qv + Q_W'(1));
         end
         if (dv_z_ff[LD]) res[i] = '0;
         any_sat = any_sat | sat[i];
      end
      rsp_in.b11_re   = res[0];
      rsp_in.b11_im   = res[1];
      rsp_in.b12_re   = res[2];
      rsp_in.b12_im   = res[3];
      rsp_in.b21_re   = res[4];
      rsp_in.b21_im   = res[5];
      rsp_in.b22_re   = res[6];
      rsp_in.b22_im   = res[7];
      rsp_in.singular = dv_z_ff[LD] | any_sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/cmi_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_checker: port-level checks of the complex 2x2 matrix inverse
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cmi_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input cmi_pkg::cmi_req_type req_data,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input cmi_pkg::cmi_rsp_type rsp_data
);
   import cmi_pkg::*;

   logic all_zero;
   assign all_zero = (rsp_data.b11_re == '0) && (rsp_data.b11_im == '0)
                  && (rsp_data.b12_re == '0) && (rsp_data.b12_im == '0)
                  && (rsp_data.b21_re == '0) && (rsp_data.b21_im == '0)
                  && (rsp_data.b22_re == '0) && (rsp_data.b22_im == '0);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   // No result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A taken or empty output lets the input advance
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready || !rsp_valid |-> req_ready)
      else $error("req_ready low while output can drain");

   // A regular inverse never truncates to all zero
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && all_zero |-> rsp_data.singular)
      else $error("all-zero inverse without singular flag");

   // Accepted input transactions carry no unknown bits
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req_data))
      else $error("accepted req transaction has unknown bits");

endmodule

bind complex_matrix2x2_inverse cmi_checker u_cmi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== test/cmi_inverse_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_inverse_checker: predicts and checks the complex 2x2 matrix inverse
// Watches both channels, computes the exact inverse of each accepted matrix
// with wide integer arithmetic, and compares every returned transaction
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cmi_inverse_checker (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  cmi_pkg::cmi_req_type  req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  cmi_pkg::cmi_rsp_type  rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import cmi_pkg::*;

   typedef logic signed [127:0] wide_t;

   cmi_rsp_type inverses_due[$];

   // Truncate |num|/den toward zero into Q16.16, saturate; bit 32 flags saturation
   function automatic logic [32:0] to_q16(input wide_t num, input wide_t den);
      wide_t mag;
      wide_t quo;
      mag = (num < 0) ? -num : num;
      quo = (mag <<< (DATA_WIDTH - 1 + Q_FRAC)) / den;
      if (num >= 0) begin
         if (quo > 128'sh7FFF_FFFF) return {1'b1, Q_POS_MAX};
         return {1'b0, quo[31:0]};
      end
      if (quo > 128'sh8000_0000) return {1'b1, Q_NEG_MAX};
      return {1'b0, 32'(-quo)};
   endfunction

   // Exact inverse B = adj(A)/D of one matrix
   function automatic cmi_rsp_type invert_matrix(input cmi_req_type a);
      wide_t x11r, x11i, x12r, x12i, x21r, x21i, x22r, x22i;
      wide_t det_re, det_im, det_mag2, nr, ni;
      wide_t er[4], ei[4];
      logic [32:0] qr, qi;
      logic [31:0] part[8];
      logic sat;
      cmi_rsp_type b;
      x11r = a.a11_re; x11i = a.a11_im; x12r = a.a12_re; x12i = a.a12_im;
      x21r = a.a21_re; x21i = a.a21_im; x22r = a.a22_re; x22i = a.a22_im;
      det_re = x11r*x22r - x11i*x22i - (x12r*x21r - x12i*x21i);
      det_im = x11r*x22i + x11i*x22r - (x12r*x21i + x12i*x21r);
      det_mag2 = det_re*det_re + det_im*det_im;
      b = '0;
      if (det_mag2 == 0) begin
         b.singular = 1'b1;
         return b;
      end
      er[0] = x22r;  ei[0] = x22i;
      er[1] = -x12r; ei[1] = -x12i;
      er[2] = -x21r; ei[2] = -x21i;
      er[3] = x11r;  ei[3] = x11i;
      sat = 1'b0;
      for (int k = 0; k < 4; k++) begin
         nr = er[k]*det_re + ei[k]*det_im;
         ni = ei[k]*det_re - er[k]*det_im;
         qr = to_q16(nr, det_mag2);
         qi = to_q16(ni, det_mag2);
         sat |= qr[32] | qi[32];
         part[2*k]   = qr[31:0];
         part[2*k+1] = qi[31:0];
      end
      b = {part[0], part[1], part[2], part[3], part[4], part[5], part[6], part[7], sat};
      return b;
   endfunction

   assign pending = inverses_due.size();

   // Predict on accepted matrices, compare accepted inverses
   always @(posedge clock) begin
      cmi_rsp_type want;
      string part_names[8];
      int errs;
      part_names = '{"b11_re", "b11_im", "b12_re", "b12_im",
                     "b21_re", "b21_im", "b22_re", "b22_im"};
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) inverses_due.push_back(invert_matrix(req_data));
         if (rsp_valid && rsp_ready) begin
            if (inverses_due.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
               errs = errs + 1;
            end else begin
               want = inverses_due.pop_front();
               for (int i = 0; i < 8; i++) begin
                  if (rsp_data[256-32*i -: 32] !== want[256-32*i -: 32]) begin
                     $display("%0t: %s mismatch, expected %h, actual %h", $time,
                              part_names[i], want[256-32*i -: 32], rsp_data[256-32*i -: 32]);
                     errs = errs + 1;
                  end
               end
               if (rsp_data.singular !== want.singular) begin
                  $display("%0t: singular mismatch, expected %b, actual %b", $time,
                           want.singular, rsp_data.singular);
                  errs = errs + 1;
               end
            end
         end
         // Count every mismatch of this cycle at once
         fail_count <= fail_count + errs;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_complex_matrix2x2_inverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_complex_matrix2x2_inverse: testbench of the complex 2x2 matrix inverse
// Drives directed corner matrices and then random, near-singular and small
// matrices with random gaps and receiver stalls; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_complex_matrix2x2_inverse;
   import cmi_pkg::*;

   localparam int LATENCY     = 39;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cmi_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cmi_rsp_type rsp_data;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   logic        calm = 1'b0;

   complex_matrix2x2_inverse DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   cmi_inverse_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL complex_matrix2x2_inverse");
         $finish;
      end
   end

   // Stall the receiver a random number of cycles after each taken transaction, except while calm
   int stall_left = 0;
   always @(posedge clock) begin
      int next_stall;
      next_stall = stall_left;
      if (!reset) begin
         if (rsp_valid && rsp_ready) next_stall = calm ? 0 : $urandom_range(0, 7);
         else if (next_stall > 0) next_stall = next_stall - 1;
      end
      stall_left <= next_stall;
      rsp_ready <= !reset && (next_stall == 0);
   end

   // Present one matrix after a random gap and hold it until accepted
   task automatic send_matrix(input cmi_req_type m);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic cmi_req_type diag_matrix(input logic [15:0] d11, input logic [15:0] d22);
      cmi_req_type m;
      m = '0;
      m.a11_re = d11;
      m.a22_re = d22;
      return m;
   endfunction

   function automatic logic [15:0] small_part();
      return 16'($signed($urandom_range(0, 64)) - 32);
   endfunction

   initial begin
      cmi_req_type m;
      int kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero matrix, scaled identity, extremes, saturation edges
      send_matrix('0);
      send_matrix(diag_matrix(16'h4000, 16'h4000));
      send_matrix(diag_matrix(16'h7FFF, 16'h7FFF));
      send_matrix(diag_matrix(16'h8000, 16'h8000));
      send_matrix(diag_matrix(16'h8000, 16'h7FFF));
      // Smallest positive parts: quotient beyond range saturates
      send_matrix(diag_matrix(16'h0001, 16'h0001));
      // Smallest negative parts: exactly -2^31, no flag
      send_matrix(diag_matrix(16'hFFFF, 16'hFFFF));
      send_matrix(diag_matrix(16'h0002, 16'hFFFE));
      m = '{16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hC000};
      send_matrix(m);
      m = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
      send_matrix(m);
      m = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
      send_matrix(m);
      m = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
      send_matrix(m);
      m = '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000};
      send_matrix(m);
      m = '{16'h1234, 16'hABCD, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF};
      send_matrix(m);

      // Random: full range, small parts, real-only, and near-singular rank-one matrices
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 100) calm <= 1'b1;
         if (n % 200 == 140) calm <= 1'b0;
         // Drain once before continuing
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 9);
         m = cmi_req_type'({$urandom, $urandom, $urandom, $urandom});
         if (kind < 2) begin
            m.a11_re = small_part(); m.a11_im = small_part();
            m.a22_re = small_part(); m.a22_im = small_part();
         end else if (kind < 4) begin
            // Second row equals the first, plus an optional one-LSB nudge
            m.a21_re = m.a11_re;
            m.a21_im = m.a11_im;
            m.a22_re = m.a12_re + 16'($urandom_range(0, 2)) - 16'd1;
            m.a22_im = m.a12_im;
         end else if (kind < 5) begin
            m.a11_im = '0; m.a12_im = '0; m.a21_im = '0; m.a22_im = '0;
         end
         send_matrix(m);
      end
      req_valid <= 1'b0;

      // Let every inverse come back, then allow for stragglers
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS complex_matrix2x2_inverse");
      end else begin
         $display("FAIL complex_matrix2x2_inverse");
      end
      $finish;
   end

endmodule
`default_nettype wire
